/* rtl/core/svp_pkg.sv */
// shared types, codes and arithmetic helpers for the sample voice player
package svp_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_STOP = 2'd2,
    MODE_TICK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_SAMPLE_LENGTH = 3'd0,
    CFG_LOOP_ENABLE   = 3'd1,
    CFG_SOURCE_STEREO = 3'd2,
    CFG_OUTPUT_STEREO = 3'd3,
    CFG_TARGET_GAIN   = 3'd4,
    CFG_TARGET_PAN    = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PAN,
    ST_MIX,
    ST_EMIT
  } state_e;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // smoothing coefficient 164/32768, rounded
  localparam logic signed [27:0] SMOOTH_COEF  = 28'sd164;
  localparam logic signed [27:0] SMOOTH_ROUND = 28'sd16384;
  localparam int                 SMOOTH_SHIFT = 15;

  // unity pan gain in Q3.15
  localparam logic signed [17:0] PAN_UNITY = 18'sd32768;

  // Q1.15 * Q1.15 * Q1.15 back to Q1.15, and one more bit for the mono average
  localparam int STEREO_SHIFT = 30;
  localparam int MONO_SHIFT   = 31;

  localparam logic [15:0] GAIN_RESET = 16'd32768;

  // one step of the one-pole smoother, cur and tgt already extended
  function automatic logic [15:0] smooth_step(input logic signed [16:0] cur,
                                              input logic signed [16:0] tgt);
    logic signed [17:0] diff;
    logic signed [27:0] scaled;
    logic signed [27:0] step;
    logic signed [17:0] sum;
    diff   = {tgt[16], tgt} - {cur[16], cur};
    scaled = diff * SMOOTH_COEF;
    scaled = scaled + SMOOTH_ROUND;
    step   = scaled >>> SMOOTH_SHIFT;
    sum    = {cur[16], cur} + step[17:0];
    return sum[15:0];
  endfunction

endpackage

/* rtl/core/svp_sample_mem.sv */
// stereo sample memory, one write port and one registered read port
module svp_sample_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_left_i,
  input  logic [DATA_W-1:0] wdata_right_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_left_o,
  output logic [DATA_W-1:0] rdata_right_o
);

  logic [DATA_W-1:0] left_mem  [DEPTH];
  logic [DATA_W-1:0] right_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      left_mem[waddr_i]  <= wdata_left_i;
      right_mem[waddr_i] <= wdata_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_left_o  <= left_mem[raddr_i];
      rdata_right_o <= right_mem[raddr_i];
    end
  end

endmodule

/* rtl/core/sample_voice_player.sv */
// top level of the sample voice player: control, smoothing and mix datapath
//
// usage
//   input channel (in_valid_i / in_ready_o) carries one request per item:
//   load, play toggle, stop or tick; output channel (out_valid_o /
//   out_ready_i) returns exactly one result per request, in order
//   config port: cfg_we_i writes cfg_data_i into register cfg_index_i at the
//   clock edge; the block leaves it to the user to write only while it is idle
// datapath
//   a tick that plays reads sample memory at accept, then passes ST_SCALE
//   (sample times gain), ST_PAN (times pan gain) and ST_MIX (round, mix and
//   saturate into the output register); every other request passes ST_EMIT
//   into the output register; one request is in flight at a time, so the
//   next request is accepted only after the last has entered the output register
// reset
//   control state and config registers take their reset values at once;
//   the sample memory is not cleared and reads as whatever was loaded
// stall
//   a finished result sits in the output register; the next request is still
//   accepted and waits in its final stage until the output register frees
module sample_voice_player #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [svp_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [svp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          mode_i,
  input  logic [15:0]                         load_address_i,
  input  logic signed [15:0]                  load_left_i,
  input  logic signed [15:0]                  load_right_i,
  input  logic signed [15:0]                  mix_in_left_i,
  input  logic signed [15:0]                  mix_in_right_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [15:0]                  mix_out_left_o,
  output logic signed [15:0]                  mix_out_right_o,
  output logic                                is_playing_o,
  output logic [15:0]                         play_position_o
);

  import svp_pkg::*;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  // length compare needs room for the full depth and for the 17 bit register
  localparam int LEN_W  = (ADDR_W + 1 > CFG_DATA_W) ? ADDR_W + 1 : CFG_DATA_W;
  // sample * gain, then * pan gain, then headroom for the mono sum
  localparam int P1_W   = SAMPLE_BITS + 17;
  localparam int P2_W   = P1_W + 18;
  localparam int ACC_W  = P2_W + 2;

  localparam logic [31:0]             MAX_U      = 32'(MAX_SAMPLES);
  localparam logic [LEN_W-1:0]        MAX_LEN    = LEN_W'(MAX_SAMPLES);
  localparam logic signed [ACC_W-1:0] RND_STEREO = ACC_W'(2 ** 29);
  localparam logic signed [ACC_W-1:0] RND_MONO   = ACC_W'(2 ** 30);
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = ACC_W'(-32768);

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > SAT_MAX) begin
      return 16'sh7fff;
    end else if (v < SAT_MIN) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // config registers
  logic [CFG_DATA_W-1:0] sample_length_q;
  logic                  loop_enable_q;
  logic                  source_stereo_q;
  logic                  output_stereo_q;
  logic [15:0]           target_gain_q;
  logic signed [15:0]    target_pan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_length_q <= '0;
      loop_enable_q   <= 1'b0;
      source_stereo_q <= 1'b1;
      output_stereo_q <= 1'b1;
      target_gain_q   <= GAIN_RESET;
      target_pan_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SAMPLE_LENGTH: sample_length_q <= cfg_data_i;
        CFG_LOOP_ENABLE:   loop_enable_q   <= cfg_data_i[0];
        CFG_SOURCE_STEREO: source_stereo_q <= cfg_data_i[0];
        CFG_OUTPUT_STEREO: output_stereo_q <= cfg_data_i[0];
        CFG_TARGET_GAIN:   target_gain_q   <= cfg_data_i[15:0];
        CFG_TARGET_PAN:    target_pan_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // voice state
  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  read_index_q, read_index_d;
  logic               active_q, active_d;
  logic               has_sample_q, has_sample_d;
  logic [15:0]        smoothed_gain_q, smoothed_gain_d;
  logic signed [15:0] smoothed_pan_q, smoothed_pan_d;

  // per-request working registers
  logic signed [15:0]      mix_left_q, mix_right_q;
  logic [ADDR_W-1:0]       cur_index_q;
  logic signed [P1_W-1:0]  prod1_left_q, prod1_right_q;
  logic signed [P2_W-1:0]  prod2_left_q, prod2_right_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] out_left_q, out_right_q;
  logic               out_playing_q;
  logic [15:0]        out_position_q;

  // handshake and control
  logic  in_fire;
  logic  out_free;
  logic  out_load;
  logic  load_from_mix;
  mode_e mode;

  assign mode     = mode_e'(mode_i);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // effective length and the position a tick starts from
  logic [LEN_W-1:0]  len_raw, len_eff;
  logic [ADDR_W-1:0] start_index;
  logic              tick_enable;

  assign len_raw     = LEN_W'(sample_length_q);
  assign len_eff     = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
  assign start_index = (LEN_W'(read_index_q) >= len_eff) ? '0 : read_index_q;
  assign tick_enable = active_q && has_sample_q && (len_eff != '0);

  // sample memory ports
  logic [31:0]             load_addr_ext;
  logic [31:0]             load_left_ext, load_right_ext;
  logic                    mem_we, mem_re;
  logic [SAMPLE_BITS-1:0]  rdata_left, rdata_right;

  assign load_addr_ext  = {16'b0, load_address_i};
  // the 16 bit field is taken to the sample width and reinterpreted there
  assign load_left_ext  = {16'b0, load_left_i};
  assign load_right_ext = {16'b0, load_right_i};
  assign mem_we = in_fire && (mode == MODE_LOAD) && (load_addr_ext < MAX_U);
  assign mem_re = in_fire && (mode == MODE_TICK) && tick_enable;

  // loads and ticks never overlap, so the read port needs no bypass
  svp_sample_mem #(
    .DEPTH  (MAX_SAMPLES),
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_mem (
    .clk_i         (clk_i),
    .we_i          (mem_we),
    .waddr_i       (load_addr_ext[ADDR_W-1:0]),
    .wdata_left_i  (load_left_ext[SAMPLE_BITS-1:0]),
    .wdata_right_i (load_right_ext[SAMPLE_BITS-1:0]),
    .re_i          (mem_re),
    .raddr_i       (start_index),
    .rdata_left_o  (rdata_left),
    .rdata_right_o (rdata_right)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ((mode == MODE_TICK) && tick_enable) ? ST_SCALE : ST_EMIT;
        end
      end
      ST_SCALE: state_d = ST_PAN;
      ST_PAN:   state_d = ST_MIX;
      ST_MIX, ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_load      = 1'b0;
    load_from_mix = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_MIX: begin
        out_load      = out_free;
        load_from_mix = 1'b1;
      end
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  // stage 1: sample times smoothed gain (mono source feeds both sides)
  logic signed [SAMPLE_BITS-1:0] x_left, x_right;
  logic signed [16:0]            gain_x;

  assign x_left  = $signed(rdata_left);
  assign x_right = source_stereo_q ? $signed(rdata_right) : $signed(rdata_left);
  assign gain_x  = $signed({1'b0, smoothed_gain_q});

  // stage 2: linear pan law
  logic signed [17:0] pan_x, pan_gain_left, pan_gain_right;

  assign pan_x          = {{2{smoothed_pan_q[15]}}, smoothed_pan_q};
  assign pan_gain_left  = (pan_x <= 18'sd0) ? PAN_UNITY : PAN_UNITY - pan_x;
  assign pan_gain_right = (pan_x >= 18'sd0) ? PAN_UNITY : PAN_UNITY + pan_x;

  // stage 3: round, add into the mix, saturate; in mono output only the left side gets the voice
  logic signed [ACC_W-1:0] p2_left_x, p2_right_x, mix_left_x, mix_right_x;
  logic signed [ACC_W-1:0] voice_left, voice_right, voice_mono;
  logic signed [15:0]      tick_left, tick_right;

  assign p2_left_x   = prod2_left_q;
  assign p2_right_x  = prod2_right_q;
  assign mix_left_x  = mix_left_q;
  assign mix_right_x = mix_right_q;
  assign voice_left  = (p2_left_x + RND_STEREO) >>> STEREO_SHIFT;
  assign voice_right = (p2_right_x + RND_STEREO) >>> STEREO_SHIFT;
  assign voice_mono  = (p2_left_x + p2_right_x + RND_MONO) >>> MONO_SHIFT;
  assign tick_left   = output_stereo_q ? sat16(mix_left_x + voice_left)
                                       : sat16(mix_left_x + voice_mono);
  assign tick_right  = output_stereo_q ? sat16(mix_right_x + voice_right) : mix_right_q;

  // position after this tick: wrap, and stop at the end unless looping
  logic [LEN_W-1:0] next_index;
  logic             at_end;

  assign next_index = LEN_W'(cur_index_q) + LEN_W'(1);
  assign at_end     = next_index >= len_eff;

  // voice state update
  always_comb begin
    read_index_d    = read_index_q;
    active_d        = active_q;
    has_sample_d    = has_sample_q;
    smoothed_gain_d = smoothed_gain_q;
    smoothed_pan_d  = smoothed_pan_q;
    if (in_fire) begin
      case (mode)
        MODE_LOAD: begin
          has_sample_d = 1'b1;
          active_d     = 1'b0;
          read_index_d = '0;
        end
        MODE_PLAY: begin
          if (has_sample_q) begin
            read_index_d = '0;
            active_d     = !active_q;
          end
        end
        MODE_STOP: begin
          active_d     = 1'b0;
          read_index_d = '0;
        end
        MODE_TICK: begin
          if (tick_enable) begin
            smoothed_gain_d = smooth_step($signed({1'b0, smoothed_gain_q}),
                                          $signed({1'b0, target_gain_q}));
            smoothed_pan_d  = smooth_step({smoothed_pan_q[15], smoothed_pan_q},
                                          {target_pan_q[15], target_pan_q});
          end
        end
        default: ;
      endcase
    end
    if (out_load && load_from_mix) begin
      if (at_end) begin
        read_index_d = '0;
        active_d     = loop_enable_q;
      end else begin
        read_index_d = next_index[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      read_index_q    <= '0;
      active_q        <= 1'b0;
      has_sample_q    <= 1'b0;
      smoothed_gain_q <= '0;
      smoothed_pan_q  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      read_index_q    <= read_index_d;
      active_q        <= active_d;
      has_sample_q    <= has_sample_d;
      smoothed_gain_q <= smoothed_gain_d;
      smoothed_pan_q  <= smoothed_pan_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  logic [31:0] pos_ext;

  assign pos_ext = 32'(read_index_d);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mix_left_q  <= mix_in_left_i;
      mix_right_q <= mix_in_right_i;
      cur_index_q <= start_index;
    end
    if (state_q == ST_SCALE) begin
      prod1_left_q  <= x_left * gain_x;
      prod1_right_q <= x_right * gain_x;
    end
    if (state_q == ST_PAN) begin
      prod2_left_q  <= prod1_left_q * pan_gain_left;
      prod2_right_q <= prod1_right_q * pan_gain_right;
    end
    if (out_load) begin
      out_left_q     <= load_from_mix ? tick_left : mix_left_q;
      out_right_q    <= load_from_mix ? tick_right : mix_right_q;
      out_playing_q  <= active_d;
      out_position_q <= pos_ext[15:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mix_out_left_o  = out_left_q;
  assign mix_out_right_o = out_right_q;
  assign is_playing_o    = out_playing_q;
  assign play_position_o = out_position_q;

endmodule
